@@ src/fsvf_pkg.sv @@
// ----------------------------------------------------------------------------
// fsvf_pkg - shared types and constants for the field serializer
// Item descriptor passed from the classifier to the byte engine.
// ----------------------------------------------------------------------------
package fsvf_pkg;

  // Format codes
  localparam logic CMD_FIXED  = 1'b0;
  localparam logic CMD_VARINT = 1'b1;

  // Width codes
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  // Varint group fields
  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic       MORE_BIT   = 1'b1;
  // Index of the last possible varint byte (ten bytes for 64 bits)
  localparam logic [3:0] VARINT_MAX_IDX = 4'd9;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified item: data already arranged so the back end always
  // takes the low bits and shifts right.
  typedef struct packed {
    logic        varint;    // 1: 7-bit groups, 0: whole bytes
    logic [63:0] data;      // prepared payload
    logic [2:0]  last_idx;  // fixed mode: index of the final byte
  } desc_t;

endpackage

@@ src/fsvf_front.sv @@
// ----------------------------------------------------------------------------
// fsvf_front - field classifier
// Holds the byte-order register, applies zigzag, orders fixed bytes and
// builds the descriptor for the back end.
// ----------------------------------------------------------------------------
module fsvf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_little_endian,
  input  logic            cmd,
  input  logic [63:0]     value,
  input  logic [1:0]      size_code,
  input  logic            zigzag,
  output fsvf_pkg::desc_t desc
);

  logic        little_endian_r;
  logic        little_endian_nxt;
  logic [63:0] fixed_data;
  logic [63:0] varint_data;
  logic [31:0] low_word;
  logic [2:0]  fixed_last;

  // Byte-order register, always writable
  assign cfg_ready         = 1'b1;
  assign little_endian_nxt = cfg_valid ? cfg_little_endian : little_endian_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b0;
    end else begin
      little_endian_r <= little_endian_nxt;
    end
  end

  // Fixed mode: select low bytes, reversed for most-significant-first
  always_comb begin
    fixed_data = 64'd0;
    fixed_last = 3'd0;
    unique case (size_code)
      fsvf_pkg::SZ_8: begin
        fixed_data = {56'd0, value[7:0]};
        fixed_last = 3'd0;
      end
      fsvf_pkg::SZ_16: begin
        fixed_last = 3'd1;
        fixed_data = little_endian_r ? {48'd0, value[15:0]}
                                     : {48'd0, value[7:0], value[15:8]};
      end
      fsvf_pkg::SZ_32: begin
        fixed_last = 3'd3;
        fixed_data = little_endian_r ? {32'd0, value[31:0]}
                                     : {32'd0, value[7:0], value[15:8],
                                        value[23:16], value[31:24]};
      end
      default: begin
        fixed_last = 3'd7;
        fixed_data = little_endian_r ? value
                                     : {value[7:0], value[15:8], value[23:16],
                                        value[31:24], value[39:32], value[47:40],
                                        value[55:48], value[63:56]};
      end
    endcase
  end

  // Varint mode: 64-bit or 32-bit, optional zigzag
  assign low_word = value[31:0];

  always_comb begin
    if (size_code == fsvf_pkg::SZ_64) begin
      varint_data = zigzag ? ({value[62:0], 1'b0} ^ {64{value[63]}}) : value;
    end else begin
      varint_data = zigzag ? {32'd0, {low_word[30:0], 1'b0} ^ {32{low_word[31]}}}
                           : {32'd0, low_word};
    end
  end

  // Descriptor
  always_comb begin
    desc.varint   = (cmd == fsvf_pkg::CMD_VARINT);
    desc.data     = (cmd == fsvf_pkg::CMD_VARINT) ? varint_data : fixed_data;
    desc.last_idx = fixed_last;
  end

endmodule

@@ src/fsvf_queue.sv @@
// ----------------------------------------------------------------------------
// fsvf_queue - descriptor queue
// Small register queue between the classifier and the byte engine.
// ----------------------------------------------------------------------------
module fsvf_queue #(
  parameter int unsigned Depth = fsvf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fsvf_pkg::desc_t wr_desc,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output fsvf_pkg::desc_t rd_desc
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fsvf_pkg::desc_t     slot_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full     = (count_r == CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_desc  = slot_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(do_wr) - CntW'(do_rd);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

@@ src/fsvf_back.sv @@
// ----------------------------------------------------------------------------
// fsvf_back - byte engine
// Walks a descriptor a byte per cycle into a registered output stage if not full.
// ----------------------------------------------------------------------------
module fsvf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  fsvf_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic        busy_r, busy_nxt;
  logic        varint_r;
  logic [63:0] data_r;
  logic [2:0]  last_idx_r;
  logic [3:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        out_ok, emit, cur_last, load;
  logic [7:0]  cur_byte;

  // Output stage may take a new byte
  assign out_ok = !ov_r || pop;
  assign emit   = busy_r && out_ok;

  // Current byte and end-of-field flag
  always_comb begin
    if (varint_r) begin
      cur_last = (data_r[63:7] == '0) || (idx_r == fsvf_pkg::VARINT_MAX_IDX);
      cur_byte = cur_last ? data_r[7:0]
                          : {fsvf_pkg::MORE_BIT, data_r[6:0] & fsvf_pkg::GROUP_MASK};
    end else begin
      cur_last = (idx_r == {1'b0, last_idx_r});
      cur_byte = data_r[7:0];
    end
  end

  // Take next item when idle or when this byte closes the field
  assign load  = q_valid && (!busy_r || (emit && cur_last));
  assign q_pop = load;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (emit) begin
      busy_nxt = !cur_last;
      idx_nxt  = idx_r + 1'b1;
    end
    ov_nxt = emit ? 1'b1 : (pop ? 1'b0 : ov_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Working data
  always_ff @(posedge clk) begin
    if (load) begin
      varint_r   <= q_desc.varint;
      data_r     <= q_desc.data;
      last_idx_r <= q_desc.last_idx;
    end else if (emit) begin
      data_r <= varint_r ? {7'd0, data_r[63:7]} : {8'd0, data_r[63:8]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
    end
  end

  assign empty    = !ov_r;
  assign out_byte = byte_r;
  assign out_last = last_r;

endmodule

@@ src/field_serializer_varint_fixed.sv @@
// ----------------------------------------------------------------------------
// field_serializer_varint_fixed - varint / zigzag and fixed-width serializer
// Turns one field item into its stream bytes, the final byte flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_cmd, in_value, in_size_code, in_zigzag and raise
//   push; the item is taken on a clock edge with push high and full low.
//   Result channel: while empty is low, out_byte / out_last hold the oldest
//   byte; it is taken on an edge with pop high. out_last marks a field's end.
//   Config channel: cfg_little_endian is written when cfg_valid is high
//   (cfg_ready is always high); write it only while the block is idle.
// Timing:
//   A taken item goes via the working register to the output register. The
//   engine emits one byte per cycle while pop keeps the output free; a field
//   is 1 to 10 bytes (ten for a wide 64-bit varint), fields follow without
//   gaps, and a two-entry descriptor queue lets items enter while bytes drain.
// Reset: synchronous, active low; queue and output empty, byte order set to
//   most significant first.
// Stall: with pop low the output holds; the engine, then the queue, fill and
//   full rises.
// ----------------------------------------------------------------------------
module field_serializer_varint_fixed #(
  parameter int unsigned QueueDepth = fsvf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_little_endian,
  // Input items
  input  logic        push,
  output logic        full,
  input  logic        in_cmd,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_size_code,
  input  logic        in_zigzag,
  // Result items
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  fsvf_pkg::desc_t front_desc;
  fsvf_pkg::desc_t q_desc;
  logic            q_valid;
  logic            q_pop;

  // Classifier
  fsvf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_little_endian (cfg_little_endian),
    .cmd               (in_cmd),
    .value             (in_value),
    .size_code         (in_size_code),
    .zigzag            (in_zigzag),
    .desc              (front_desc)
  );

  // Descriptor queue
  fsvf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_desc  (front_desc),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_desc  (q_desc)
  );

  // Byte engine
  fsvf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

@@ tb/tb_field_serializer_varint_fixed.sv @@
// ----------------------------------------------------------------------------
// tb_field_serializer_varint_fixed - self-checking bench for the serializer
// Fields go in through the push/full queue and come out one byte at a time.
// A scoreboard class predicts each field's bytes in fixed and varint mode
// (zigzag, narrow widths, both byte orders) and checks every popped byte in
// order. Both sides idle in random bursts. One phase holds the output long
// enough to fill the block, and the byte order is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_field_serializer_varint_fixed;

  // Expected byte stream and the byte-order copy it is predicted with
  class field_scoreboard;
    logic [7:0] exp_data_q[$];
    logic       exp_last_q[$];
    logic       lsb_first;
    int         n_errors;
    int         n_fixed;
    int         n_varint;
    int         n_bytes;

    function new();
      lsb_first = 1'b0;
      n_errors  = 0;
      n_fixed   = 0;
      n_varint  = 0;
      n_bytes   = 0;
    endfunction

    function void set_order(logic le);
      lsb_first = le;
    endfunction

    function int pending();
      return exp_data_q.size();
    endfunction

    // Append one expected byte at the tail
    function void add_expect(logic [7:0] b, logic l);
      exp_data_q.insert(exp_data_q.size(), b);
      exp_last_q.insert(exp_last_q.size(), l);
    endfunction

    // Work out the bytes of one accepted field and queue them
    function void note_field(logic c, logic [63:0] v, logic [1:0] sz, logic zz);
      logic [63:0] w;
      int          nb;
      int          pos;
      if (c == fsvf_pkg::CMD_FIXED) begin
        n_fixed++;
        nb = 1 << sz;
        for (int i = 0; i < nb; i++) begin
          pos = lsb_first ? i : nb - 1 - i;
          add_expect(v[pos*8 +: 8], i == nb - 1);
        end
      end else begin
        n_varint++;
        // 8 and 16 bit varints are handled as 32 bit
        if (sz == fsvf_pkg::SZ_64)
          w = zz ? ((v << 1) ^ {64{v[63]}}) : v;
        else
          w = zz ? {32'd0, (v[31:0] << 1) ^ {32{v[31]}}} : {32'd0, v[31:0]};
        // 7-bit groups, least significant first, continuation flag on top
        while (w > 64'(fsvf_pkg::GROUP_MASK)) begin
          add_expect({fsvf_pkg::MORE_BIT, w[6:0] & fsvf_pkg::GROUP_MASK}, 1'b0);
          w = w >> 7;
        end
        add_expect(w[7:0], 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      n_errors++;
    endtask

    // Compare a popped byte with the oldest expectation
    task check_byte(logic [7:0] b, logic l);
      logic [7:0] ed;
      logic       el;
      if (exp_data_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", b, l));
      end else begin
        ed = exp_data_q.pop_front();
        el = exp_last_q.pop_front();
        n_bytes++;
        if (b !== ed)
          report_mismatch($sformatf("byte %0d: got %02h, want %02h", n_bytes, b, ed));
        if (l !== el)
          report_mismatch($sformatf("byte %0d: last %0b, want %0b", n_bytes, l, el));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_little_endian;
  logic        push;
  logic        full;
  logic        in_cmd;
  logic [63:0] in_value;
  logic [1:0]  in_size_code;
  logic        in_zigzag;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_last;

  field_scoreboard sb = new();

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int full_stalls;

  field_serializer_varint_fixed uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_little_endian (cfg_little_endian),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .in_size_code      (in_size_code),
    .in_zigzag         (in_zigzag),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last          (out_last)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Check every byte taken from the output
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_byte(out_byte, out_last);
    if (rst_n && push && full)
      full_stalls++;
  end

  // Receiver: random pop bursts, plus one long hold counted here
  initial begin : rx_drive
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one field and wait until it is taken; called at a falling edge
  task automatic send_field(input logic c, input logic [63:0] v,
                            input logic [1:0] sz, input logic zz);
    push         <= 1'b1;
    in_cmd       <= c;
    in_value     <= v;
    in_size_code <= sz;
    in_zigzag    <= zz;
    do @(posedge clk); while (full);
    sb.note_field(c, v, sz, zz);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Stop offering and let every expected byte come out
  task automatic wait_drained();
    if (push)
      push <= 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_byte_order(input logic le);
    cfg_valid         <= 1'b1;
    cfg_little_endian <= le;
    do @(posedge clk); while (!cfg_ready);
    sb.set_order(le);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Extremes, byte order patterns and the varint corner cases
  task automatic run_directed();
    send_field(fsvf_pkg::CMD_FIXED, 64'h0102_0304_0506_0708, fsvf_pkg::SZ_8, 1'b0);
    // zigzag ignored
    send_field(fsvf_pkg::CMD_FIXED, 64'h0102_0304_0506_0708, fsvf_pkg::SZ_16, 1'b1);
    send_field(fsvf_pkg::CMD_FIXED, 64'h0102_0304_0506_0708, fsvf_pkg::SZ_32, 1'b0);
    send_field(fsvf_pkg::CMD_FIXED, 64'hF1E2_D3C4_B5A6_9788, fsvf_pkg::SZ_64, 1'b1);
    send_field(fsvf_pkg::CMD_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, fsvf_pkg::SZ_64, 1'b0);
    send_field(fsvf_pkg::CMD_FIXED, 64'h0,                   fsvf_pkg::SZ_64, 1'b0);
    // narrow varint
    send_field(fsvf_pkg::CMD_VARINT, 64'h0,                   fsvf_pkg::SZ_8,  1'b0);
    send_field(fsvf_pkg::CMD_VARINT, 64'h7F,                  fsvf_pkg::SZ_16, 1'b0);
    // high bits dropped
    send_field(fsvf_pkg::CMD_VARINT, 64'hFFFF_FFFF_0000_0080, fsvf_pkg::SZ_32, 1'b0);
    // negative, unsigned
    send_field(fsvf_pkg::CMD_VARINT, 64'hFFFF_FFFF_FFFF_FFFF, fsvf_pkg::SZ_32, 1'b0);
    // ten bytes
    send_field(fsvf_pkg::CMD_VARINT, 64'hFFFF_FFFF_FFFF_FFFF, fsvf_pkg::SZ_64, 1'b0);
    // most negative
    send_field(fsvf_pkg::CMD_VARINT, 64'h0000_0000_8000_0000, fsvf_pkg::SZ_32, 1'b1);
    send_field(fsvf_pkg::CMD_VARINT, 64'h8000_0000_0000_0000, fsvf_pkg::SZ_64, 1'b1);
    // minus one
    send_field(fsvf_pkg::CMD_VARINT, 64'hFFFF_FFFF_FFFF_FFFF, fsvf_pkg::SZ_16, 1'b1);
  endtask

  // Random fields, values shaped to spread over all varint lengths
  task automatic run_random(input int n);
    logic [63:0] raw;
    logic [63:0] v;
    for (int i = 0; i < n; i++) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: v = raw;
        1: v = raw >> $urandom_range(0, 63);
        2: v = -(raw >> $urandom_range(20, 63));
        3: v = (64'h1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        default: v = {raw[63:32] & {32{raw[0]}}, raw[31:0] >> $urandom_range(0, 31)};
      endcase
      send_field(1'($urandom_range(0, 1)), v, 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Main sequence
  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_little_endian = 1'b0;
    push              = 1'b0;
    in_cmd            = fsvf_pkg::CMD_FIXED;
    in_value          = 64'h0;
    in_size_code      = fsvf_pkg::SZ_8;
    in_zigzag         = 1'b0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    hold_req          = 1'b0;
    full_stalls       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Byte order from reset, then swapped
    run_directed();
    wait_drained();
    write_byte_order(1'b1);
    run_directed();
    run_random(110);
    wait_drained();

    // Output held off while the sender keeps pushing
    write_byte_order(1'b0);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_random(40);
    wait_drained();

    tx_idle_en = 1'b1;
    run_random(82);
    wait_drained();

    // Final stretch at full rate on both sides
    write_byte_order(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(100);
    wait_drained();
    repeat (20) @(negedge clk);

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d bytes never arrived", sb.pending()));
    $display("Covered %0d fixed and %0d varint fields, %0d bytes checked, both byte orders.",
             sb.n_fixed, sb.n_varint, sb.n_bytes);
    $display("Input held back by a full block on %0d cycles; %0d mismatches.",
             full_stalls, sb.n_errors);
    if (sb.n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
